// ===== design/wcarf_pkg.sv =====
// ----------------------------------------------------------------------------
// wcarf_pkg: shared types and constants of the wildcard access rule filter
// Command and result words, rule layout, kind codes and the digit matcher.
// ----------------------------------------------------------------------------
package wcarf_pkg;

    localparam int unsigned MAX_RULES_DEFAULT   = 1024;
    localparam int unsigned ADDR_DIGITS_DEFAULT = 8;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned MASK_W     = 8;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned RIDX_W     = 10;
    localparam int unsigned S_TDATA_W  = 88;
    localparam int unsigned M_TDATA_W  = 16;

    // Command queue between front and back end
    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    // Item kind codes on s_tuser
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLASSIFY = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_CLASSIFY,
        OP_NOP
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } bstate_t;

    typedef struct packed {
        op_t               op;
        logic              permit;
        logic [ADDR_W-1:0] src_digits;
        logic [MASK_W-1:0] src_mask;
        logic [ADDR_W-1:0] dst_digits;
        logic [MASK_W-1:0] dst_mask;
    } cmd_t;

    typedef struct packed {
        logic              permit;
        logic [ADDR_W-1:0] dst_digits;
        logic [MASK_W-1:0] dst_mask;
        logic [ADDR_W-1:0] src_digits;
        logic [MASK_W-1:0] src_mask;
    } rule_t;

    typedef struct packed {
        logic              rule_dropped;
        logic [RIDX_W-1:0] rule_index;
        logic              matched;
        logic              accepted;
    } res_t;

    // A digit matches when wildcarded or equal; only the first ndig digits count
    function automatic logic digits_match(input logic [ADDR_W-1:0] pat,
                                          input logic [MASK_W-1:0] msk,
                                          input logic [ADDR_W-1:0] addr,
                                          input int unsigned       ndig);
        logic ok;
        ok = 1'b1;
        for (int d = 0; d < 8; d++) begin
            if (d < ndig) begin
                if (!msk[7-d] && (pat[(7-d)*4 +: 4] != addr[(7-d)*4 +: 4])) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

// ===== design/wcarf_ram.sv =====
// ----------------------------------------------------------------------------
// wcarf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wcarf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/wcarf_front.sv =====
// ----------------------------------------------------------------------------
// wcarf_front: input side of the rule filter
// Accept words, decode the kind into an operation and queue the command.
// ----------------------------------------------------------------------------
module wcarf_front import wcarf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [KIND_W-1:0]    s_tuser,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd
);

    cmd_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              dec;
    logic              push, pop;

    always_comb begin
        dec.permit     = s_tdata[0];
        dec.src_digits = s_tdata[32:1];
        dec.src_mask   = s_tdata[40:33];
        dec.dst_digits = s_tdata[72:41];
        dec.dst_mask   = s_tdata[80:73];
        case (s_tuser)
            KIND_CLEAR:    dec.op = OP_CLEAR;
            KIND_APPEND:   dec.op = OP_APPEND;
            KIND_CLASSIFY: dec.op = OP_CLASSIFY;
            default:       dec.op = OP_NOP;
        endcase
    end

    assign s_tready  = (cnt_reg != QCNT_W'(QDEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ===== design/wcarf_back.sv =====
// ----------------------------------------------------------------------------
// wcarf_back: execution side of the rule filter
// Clear and append the rule table, scan it newest first for a packet.
// ----------------------------------------------------------------------------
module wcarf_back import wcarf_pkg::*; #(
    parameter int unsigned MAX_RULES   = MAX_RULES_DEFAULT,
    parameter int unsigned ADDR_DIGITS = ADDR_DIGITS_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic m_tvalid,
    input  logic m_tready,
    output res_t res
);

    localparam int unsigned AW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);
    localparam int unsigned EXT_W = (AW > RIDX_W) ? AW : RIDX_W;

    bstate_t           state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    res_t              res_reg, res_next;
    logic [ADDR_W-1:0] pkt_src_reg, pkt_src_next;
    logic [ADDR_W-1:0] pkt_dst_reg, pkt_dst_next;

    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    rule_t             wr_rule, rd_rule;
    logic [$bits(rule_t)-1:0] rd_word;

    logic              out_free, pop, full, hit;
    logic [CNT_W-1:0]  cnt_m1;
    logic [EXT_W-1:0]  idx_ext;

    wcarf_ram #(
        .WIDTH ($bits(rule_t)),
        .DEPTH (MAX_RULES)
    ) u_rules (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_rule),
        .raddr (ram_raddr),
        .rdata (rd_word)
    );

    assign rd_rule   = rule_t'(rd_word);
    assign out_free  = !out_valid_reg || m_tready;
    assign cmd_ready = (state_reg == ST_IDLE) && out_free;
    assign pop       = cmd_valid && cmd_ready;
    assign full      = (count_reg == CNT_W'(MAX_RULES));
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign idx_ext   = EXT_W'(idx_reg);
    assign hit       = digits_match(rd_rule.src_digits, rd_rule.src_mask,
                                    pkt_src_reg, ADDR_DIGITS) &&
                       digits_match(rd_rule.dst_digits, rd_rule.dst_mask,
                                    pkt_dst_reg, ADDR_DIGITS);

    assign wr_rule.permit     = cmd.permit;
    assign wr_rule.dst_digits = cmd.dst_digits;
    assign wr_rule.dst_mask   = cmd.dst_mask;
    assign wr_rule.src_digits = cmd.src_digits;
    assign wr_rule.src_mask   = cmd.src_mask;

    assign m_tvalid = out_valid_reg;
    assign res      = res_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop && cmd.op == OP_CLASSIFY && count_reg != '0) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit || idx_reg == '0) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        res_next       = res_reg;
        pkt_src_next   = pkt_src_reg;
        pkt_dst_next   = pkt_dst_reg;
        ram_we         = 1'b0;
        ram_raddr      = idx_reg - 1'b1;
        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    res_next = '0;
                    case (cmd.op)
                        OP_CLEAR: begin
                            count_next     = '0;
                            out_valid_next = 1'b1;
                        end
                        OP_APPEND: begin
                            out_valid_next = 1'b1;
                            if (full) begin
                                res_next.rule_dropped = 1'b1;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_CLASSIFY: begin
                            pkt_src_next = cmd.src_digits;
                            pkt_dst_next = cmd.dst_digits;
                            ram_raddr    = cnt_m1[AW-1:0];
                            idx_next     = cnt_m1[AW-1:0];
                            // empty table: deny at once
                            if (count_reg == '0) begin
                                out_valid_next = 1'b1;
                            end
                        end
                        default: begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    res_next.accepted     = rd_rule.permit;
                    res_next.matched      = 1'b1;
                    res_next.rule_index   = idx_ext[RIDX_W-1:0];
                    res_next.rule_dropped = 1'b0;
                    out_valid_next        = 1'b1;
                end else if (idx_reg == '0) begin
                    res_next       = '0;
                    out_valid_next = 1'b1;
                end else begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg     <= res_next;
        pkt_src_reg <= pkt_src_next;
        pkt_dst_reg <= pkt_dst_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_RULES))
        else $error("rule count beyond table depth");

    a_scan_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> !out_valid_reg)
        else $error("result pending while a scan runs");

    a_write_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !full && state_reg == ST_IDLE)
        else $error("rule write into full table");

    a_match_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && pop) |=> !(out_valid_reg && res_reg.matched))
        else $error("match reported without a scan");

endmodule

// ===== design/wildcard_access_rule_filter.sv =====
// ----------------------------------------------------------------------------
// wildcard_access_rule_filter: ordered permit/deny rule table
// Per-digit wildcard matching of source and destination BCD addresses.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one command word per handshake; s_tuser selects
//   clear table, append rule or classify packet. Every word yields exactly
//   one result word on the master channel, in order.
//   A front end decodes words into a two-entry command queue; a back end
//   executes them against a rule RAM of MAX_RULES entries.
//   Clear and append results pass through the command queue entry and the
//   result register before m_tvalid. Classify reads one rule per cycle
//   through the RAM's single read port, newest first, and stops at the
//   first hit; an empty table gives a deny result without a scan.
//   The back end takes one command per pass: a classify word holds it until
//   its scan ends; clear and append go one per cycle while m_tready is high.
//   Reset (aresetn low, synchronous) empties the table and the queue; rule
//   contents are not cleared, only the count, so no sweep is needed.
//   When m_tready stays low the result holds in its register, the back end
//   stops, and the queue fills up before s_tready drops.
// ----------------------------------------------------------------------------
module wildcard_access_rule_filter import wcarf_pkg::*; #(
    parameter int unsigned MAX_RULES   = MAX_RULES_DEFAULT,
    parameter int unsigned ADDR_DIGITS = ADDR_DIGITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // slave channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: permit[0], src_digits[32:1], src_wild_mask[40:33],
    //        dst_digits[72:41], dst_wild_mask[80:73], zero pad[87:81]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // tuser: kind[1:0]
    input  logic [KIND_W-1:0]    s_tuser,
    // master channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata: accepted[0], matched[1], rule_index[11:2], rule_dropped[12],
    //        zero pad[15:13]
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    res_t res;

    // Accept and decode words, buffer them for the back end
    wcarf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Execute commands against the rule table
    wcarf_back #(
        .MAX_RULES   (MAX_RULES),
        .ADDR_DIGITS (ADDR_DIGITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .res       (res)
    );

    // Pack the result word, pad the top bits with zeros
    assign m_tdata = {{(M_TDATA_W - $bits(res_t)){1'b0}},
                      res.rule_dropped, res.rule_index, res.matched, res.accepted};

endmodule
